// File: rtl/swbct_pkg.sv
// shared constants and types for the swept box collision time unit
package swbct_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int TIME_FRAC_BITS_DEF = 16;

  // two-bit signed normal codes
  localparam logic [1:0] NORM_ZERO = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

  // control flags carried alongside each transaction
  typedef struct packed {
    logic rej;      // no hit
    logic inf_x;    // zero x motion, unbounded x window
    logic inf_y;    // zero y motion, unbounded y window
    logic dxp;      // move_x > 0
    logic dyp;      // move_y > 0
    logic x_later;  // x entry strictly later than y entry
  } flags_t;

endpackage

// File: rtl/swbct_setup.sv
// broad phase, degenerate checks and per-axis entry and exit fractions
module swbct_setup #(
  parameter int W  = swbct_pkg::COORD_WIDTH_DEF,
  parameter int NW = W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [W-1:0]  ml, mt, mr, mb, dx, dy, sl, st, sr, sb,
  output logic                 v_r,
  output swbct_pkg::flags_t    f_r,
  output logic signed [NW-1:0] enx_r, exx_r, dnx_r, eny_r, exy_r, dny_r
);

  logic signed [NW-1:0] e_ml, e_mt, e_mr, e_mb, e_dx, e_dy, e_sl, e_st, e_sr, e_sb;
  logic signed [NW-1:0] bl, bt, br, bb;
  logic                 dxp, dyp, dxz, dyz, miss;
  swbct_pkg::flags_t    f_nxt;

  always_comb begin
    e_ml = NW'(ml); e_mt = NW'(mt); e_mr = NW'(mr); e_mb = NW'(mb);
    e_dx = NW'(dx); e_dy = NW'(dy);
    e_sl = NW'(sl); e_st = NW'(st); e_sr = NW'(sr); e_sb = NW'(sb);
    dxz  = (dx == '0);
    dyz  = (dy == '0);
    dxp  = !dx[W-1] && !dxz;
    dyp  = !dy[W-1] && !dyz;
    // swept box over the whole move
    bl   = dxp ? e_ml : e_ml + e_dx;
    br   = dxp ? e_mr + e_dx : e_mr;
    bt   = dyp ? e_mt : e_mt + e_dy;
    bb   = dyp ? e_mb + e_dy : e_mb;
    miss = (br < e_sl) || (bl > e_sr) || (bb < e_st) || (bt > e_sb);
    f_nxt.rej     = miss || (dxz && dyz) || (st == sb) || (sl == sr);
    f_nxt.inf_x   = dxz;
    f_nxt.inf_y   = dyz;
    f_nxt.dxp     = dxp;
    f_nxt.dyp     = dyp;
    f_nxt.x_later = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_nxt;
      if (dxp) begin
        enx_r <= e_sl - e_mr;
        exx_r <= e_sr - e_ml;
        dnx_r <= e_dx;
      end else begin
        enx_r <= e_ml - e_sr;
        exx_r <= e_mr - e_sl;
        dnx_r <= -e_dx;
      end
      if (dyp) begin
        eny_r <= e_st - e_mb;
        exy_r <= e_sb - e_mt;
        dny_r <= e_dy;
      end else begin
        eny_r <= e_mt - e_sb;
        exy_r <= e_mb - e_st;
        dny_r <= -e_dy;
      end
    end
  end

endmodule

// File: rtl/swbct_select.sv
// exact cross-multiplied compares: later entry, earlier exit, final reject
module swbct_select #(
  parameter int NW = swbct_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_in,
  input  swbct_pkg::flags_t    f_in,
  input  logic signed [NW-1:0] enx, exx, dnx, eny, exy, dny,
  output logic                 v_r,
  output swbct_pkg::flags_t    f_r,
  output logic signed [NW-1:0] num_r,
  output logic signed [NW-1:0] den_r
);

  localparam int PW = 2 * NW;

  // stage a: early rejects and cross products
  logic                 va_r;
  swbct_pkg::flags_t    fa_r, fa_nxt;
  logic signed [NW-1:0] enx_a, exx_a, dnx_a, eny_a, exy_a, dny_a;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r;
  // stage b: pick entry and exit
  logic                 vb_r;
  swbct_pkg::flags_t    fb_r, fb_nxt;
  logic signed [NW-1:0] ten_r, ted_r, txn_r, txd_r;
  logic                 x_later;
  logic                 x_exit;
  // stage c: entry against exit
  logic                 vc_r;
  swbct_pkg::flags_t    fc_r, fd_nxt;
  logic signed [NW-1:0] ten_c, ted_c;
  logic signed [PW-1:0] q1_r, q2_r;

  always_comb begin
    fa_nxt     = f_in;
    fa_nxt.rej = f_in.rej
               || ((f_in.inf_x || enx < 0) && (f_in.inf_y || eny < 0))
               || (!f_in.inf_x && enx > dnx)
               || (!f_in.inf_y && eny > dny);
  end

  always_comb begin
    if (fa_r.inf_x) begin
      x_later = 1'b0;
    end else if (fa_r.inf_y) begin
      x_later = 1'b1;
    end else begin
      x_later = p1_r > p2_r;
    end
    if (fa_r.inf_x) begin
      x_exit = 1'b0;
    end else if (fa_r.inf_y) begin
      x_exit = 1'b1;
    end else begin
      x_exit = p3_r < p4_r;
    end
    fb_nxt         = fa_r;
    fb_nxt.x_later = x_later;
  end

  always_comb begin
    fd_nxt     = fc_r;
    fd_nxt.rej = fc_r.rej || (q1_r > q2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      v_r  <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
      vc_r <= vb_r;
      v_r  <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r  <= fa_nxt;
      enx_a <= enx; exx_a <= exx; dnx_a <= dnx;
      eny_a <= eny; exy_a <= exy; dny_a <= dny;
      p1_r  <= enx * dny;
      p2_r  <= eny * dnx;
      p3_r  <= exx * dny;
      p4_r  <= exy * dnx;

      fb_r  <= fb_nxt;
      ten_r <= x_later ? enx_a : eny_a;
      ted_r <= x_later ? dnx_a : dny_a;
      txn_r <= x_exit ? exx_a : exy_a;
      txd_r <= x_exit ? dnx_a : dny_a;

      fc_r  <= fb_r;
      ten_c <= ten_r;
      ted_c <= ted_r;
      q1_r  <= ten_r * txd_r;
      q2_r  <= txn_r * ted_r;

      f_r   <= fd_nxt;
      num_r <= ten_c;
      den_r <= ted_c;
    end
  end

endmodule

// File: rtl/swbct_div.sv
// restoring divider, one quotient bit per pipeline stage
module swbct_div #(
  parameter int NW = swbct_pkg::COORD_WIDTH_DEF + 1,
  parameter int F  = swbct_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  swbct_pkg::flags_t f_in,
  input  logic [NW-1:0]     num,
  input  logic [NW-1:0]     den,
  output logic              v_out,
  output swbct_pkg::flags_t f_out,
  output logic [F:0]        q_out
);

  logic [NW-1:0]     r_r [0:F];
  logic [NW-1:0]     d_r [0:F];
  logic [F:0]        q_r [0:F];
  swbct_pkg::flags_t f_r [0:F];
  logic [F:0]        v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[F-1:0], v_in};
    end
  end

  // integer bit
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= (num >= den) ? num - den : num;
      q_r[0] <= {{F{1'b0}}, (num >= den)};
      d_r[0] <= den;
      f_r[0] <= f_in;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_stage
    logic [NW-1:0] rs;
    logic          ge;
    always_comb begin
      rs = {r_r[k-1][NW-2:0], 1'b0};
      ge = rs >= d_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= ge ? rs - d_r[k-1] : rs;
        q_r[k] <= {q_r[k-1][F-1:0], ge};
        d_r[k] <= d_r[k-1];
        f_r[k] <= f_r[k-1];
      end
    end
  end

  assign v_out = v_r[F];
  assign f_out = f_r[F];
  assign q_out = q_r[F];

endmodule

// File: rtl/swept_box_collision_time_unit.sv
// top level of the swept box collision time unit
// throughput: one transaction per cycle while the output is not stalled; the divider chain sets the depth
// one global stall: every stage holds while the output register is full and not taken
// reset: synchronous active-low rst_n clears all valid bits; payload is not reset
module swept_box_collision_time_unit #(
  parameter int COORD_WIDTH    = swbct_pkg::COORD_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = swbct_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_moving_left,
  input  logic signed [COORD_WIDTH-1:0] in_moving_top,
  input  logic signed [COORD_WIDTH-1:0] in_moving_right,
  input  logic signed [COORD_WIDTH-1:0] in_moving_bottom,
  input  logic signed [COORD_WIDTH-1:0] in_move_x,
  input  logic signed [COORD_WIDTH-1:0] in_move_y,
  input  logic signed [COORD_WIDTH-1:0] in_static_left,
  input  logic signed [COORD_WIDTH-1:0] in_static_top,
  input  logic signed [COORD_WIDTH-1:0] in_static_right,
  input  logic signed [COORD_WIDTH-1:0] in_static_bottom,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [TIME_FRAC_BITS:0]      out_contact_time,
  output logic signed [1:0]            out_normal_x,
  output logic signed [1:0]            out_normal_y
);

  localparam int NW = COORD_WIDTH + 1;

  logic                 en;
  // setup stage outputs
  logic                 v1;
  swbct_pkg::flags_t    f1;
  logic signed [NW-1:0] enx, exx, dnx, eny, exy, dny;
  // compare stages outputs
  logic                 v2;
  swbct_pkg::flags_t    f2;
  logic signed [NW-1:0] num, den;
  // divider outputs, last stage is the output register
  swbct_pkg::flags_t    f3;
  logic [TIME_FRAC_BITS:0] q;

  // the pipeline advances whenever the output register is empty or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  swbct_setup #(.W(COORD_WIDTH), .NW(NW)) u_setup (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid && in_ready),
    .ml(in_moving_left), .mt(in_moving_top), .mr(in_moving_right),
    .mb(in_moving_bottom), .dx(in_move_x), .dy(in_move_y),
    .sl(in_static_left), .st(in_static_top), .sr(in_static_right),
    .sb(in_static_bottom),
    .v_r(v1), .f_r(f1),
    .enx_r(enx), .exx_r(exx), .dnx_r(dnx), .eny_r(eny), .exy_r(exy), .dny_r(dny)
  );

  swbct_select #(.NW(NW)) u_select (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(v1), .f_in(f1),
    .enx(enx), .exx(exx), .dnx(dnx), .eny(eny), .exy(exy), .dny(dny),
    .v_r(v2), .f_r(f2), .num_r(num), .den_r(den)
  );

  // entry numerator is in [0, den] for any transaction that is not rejected
  swbct_div #(.NW(NW), .F(TIME_FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(v2), .f_in(f2),
    .num(NW'(unsigned'(num))), .den(NW'(unsigned'(den))),
    .v_out(out_valid), .f_out(f3), .q_out(q)
  );

  // result fields, all zero on a miss
  always_comb begin
    out_hit          = !f3.rej;
    out_contact_time = f3.rej ? '0 : q;
    out_normal_x     = swbct_pkg::NORM_ZERO;
    out_normal_y     = swbct_pkg::NORM_ZERO;
    if (!f3.rej) begin
      if (f3.x_later) begin
        out_normal_x = f3.dxp ? swbct_pkg::NORM_NEG : swbct_pkg::NORM_POS;
      end else begin
        out_normal_y = f3.dyp ? swbct_pkg::NORM_NEG : swbct_pkg::NORM_POS;
      end
    end
  end

  // a miss reports nothing but zeros
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_contact_time == '0
                              && out_normal_x == swbct_pkg::NORM_ZERO
                              && out_normal_y == swbct_pkg::NORM_ZERO)
    else $error("miss with nonzero fields");

  // a hit has exactly one nonzero normal
  a_hit_normal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_normal_x != swbct_pkg::NORM_ZERO)
                             != (out_normal_y != swbct_pkg::NORM_ZERO))
    else $error("hit normal not on exactly one axis");

  // contact time never exceeds one full move
  a_time_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_contact_time <= {1'b1, {TIME_FRAC_BITS{1'b0}}})
    else $error("contact time above one");

  // a stalled result blocks new input transactions
  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
